[hdl/cache_set_lru_mesi_macros.svh]
// ----------------------------------------------------------------------------
// cache_set_lru_mesi_macros
// Assertion macros used by the checker file of the cache set.
// ----------------------------------------------------------------------------
`ifndef CACHE_SET_LRU_MESI_MACROS_SVH
`define CACHE_SET_LRU_MESI_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("cache set check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("cache set check failed");

`endif

[hdl/csl_pkg.sv]
// ----------------------------------------------------------------------------
// csl_pkg
// Types, sizes and helpers of the LRU/MESI cache set.
// ----------------------------------------------------------------------------
package csl_pkg;

  localparam int WAYS      = 8;
  localparam int TAG_BITS  = 12;
  localparam int RANK_BITS = $clog2(WAYS);
  localparam int CNT_BITS  = $clog2(WAYS + 1);
  localparam int TYPE_BITS = 3;

  typedef enum logic [TYPE_BITS-1:0] {
    RT_READ  = 3'd0,
    RT_WRITE = 3'd1,
    RT_SNOOP = 3'd2,
    RT_INV   = 3'd3,
    RT_CLEAR = 3'd4
  } req_type_e;

  typedef enum logic [1:0] {
    ST_I = 2'd0,
    ST_S = 2'd1,
    ST_E = 2'd2,
    ST_M = 2'd3
  } mesi_e;

  typedef logic [TAG_BITS-1:0]               tag_t;
  typedef logic [RANK_BITS-1:0]              rank_t;
  typedef logic [WAYS-1:0]                   way_vec_t;
  typedef logic [WAYS-1:0][TAG_BITS-1:0]     tag_arr_t;
  typedef mesi_e [WAYS-1:0]                  st_arr_t;
  typedef logic [WAYS-1:0][RANK_BITS-1:0]    rank_arr_t;

  localparam rank_t RANK_MAX = RANK_BITS'(WAYS - 1);

  // Result of the parallel tag and rank lookup.
  typedef struct packed {
    logic     hit;
    way_vec_t hit_oh;
    mesi_e    hit_st;
    rank_t    hit_rank;
    way_vec_t free_oh;
    way_vec_t lru_oh;
    mesi_e    lru_st;
    rank_t    lru_rank;
    tag_t     lru_tag;
    way_vec_t mod_mask;
  } lookup_t;

  typedef struct packed {
    logic hit;
    logic fetch_from_l2;
    logic write_through;
    logic writeback;
    tag_t victim_tag;
    logic snoop_return;
    logic last;
  } rsp_t;

  // Picks the tag of the way flagged in a one-hot vector.
  function automatic tag_t oh_tag(way_vec_t oh, tag_arr_t tags);
    tag_t t;
    t = '0;
    for (int k = 0; k < WAYS; k++) begin
      t = t | (tags[k] & {TAG_BITS{oh[k]}});
    end
    return t;
  endfunction

endpackage

[hdl/csl_if.sv]
// ----------------------------------------------------------------------------
// csl_if
// Request and response channels of the cache set, valid/ready handshake.
// ----------------------------------------------------------------------------
interface csl_req_if;
  import csl_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [TYPE_BITS-1:0] req_type;
  logic [TAG_BITS-1:0]  req_tag;

  modport source (output valid, output req_type, output req_tag, input ready);
  modport sink   (input valid, input req_type, input req_tag, output ready);
endinterface

interface csl_rsp_if;
  import csl_pkg::*;

  logic                valid;
  logic                ready;
  logic                hit;
  logic                fetch_from_l2;
  logic                write_through;
  logic                writeback;
  logic [TAG_BITS-1:0] victim_tag;
  logic                snoop_return;
  logic                last;

  modport source (output valid, output hit, output fetch_from_l2, output write_through,
                  output writeback, output victim_tag, output snoop_return,
                  output last, input ready);
  modport sink   (input valid, input hit, input fetch_from_l2, input write_through,
                  input writeback, input victim_tag, input snoop_return,
                  input last, output ready);
endinterface

[hdl/csl_lookup.sv]
// ----------------------------------------------------------------------------
// csl_lookup
// Parallel tag compare, free-way and LRU-way selection over all ways.
// ----------------------------------------------------------------------------
module csl_lookup (
  input  csl_pkg::tag_t      tag_i,
  input  csl_pkg::tag_arr_t  tags_i,
  input  csl_pkg::st_arr_t   st_i,
  input  csl_pkg::rank_arr_t rank_i,
  output csl_pkg::lookup_t   lk_o
);
  import csl_pkg::*;

  way_vec_t valid_w;
  way_vec_t invalid_w;
  way_vec_t match_w;
  way_vec_t lru_w;
  way_vec_t mod_w;
  mesi_e    hit_st_w;
  mesi_e    lru_st_w;
  rank_t    hit_rank_w;
  rank_t    lru_rank_w;

  always_comb begin
    hit_st_w   = ST_I;
    lru_st_w   = ST_I;
    hit_rank_w = '0;
    lru_rank_w = '0;
    for (int k = 0; k < WAYS; k++) begin
      valid_w[k] = (st_i[k] != ST_I);
      match_w[k] = valid_w[k] && (tags_i[k] == tag_i);
      // With the set full the ranks are a permutation, so exactly one way
      // holds the highest rank.
      lru_w[k]   = valid_w[k] && (rank_i[k] == RANK_MAX);
      mod_w[k]   = (st_i[k] == ST_M);
      if (match_w[k]) begin
        hit_st_w   = mesi_e'(hit_st_w | st_i[k]);
        hit_rank_w = hit_rank_w | rank_i[k];
      end
      if (lru_w[k]) begin
        lru_st_w   = mesi_e'(lru_st_w | st_i[k]);
        lru_rank_w = lru_rank_w | rank_i[k];
      end
    end
    invalid_w = ~valid_w;
  end

  assign lk_o.hit      = |match_w;
  assign lk_o.hit_oh   = match_w;
  assign lk_o.hit_st   = hit_st_w;
  assign lk_o.hit_rank = hit_rank_w;
  assign lk_o.free_oh  = invalid_w & (~invalid_w + way_vec_t'(1));
  assign lk_o.lru_oh   = lru_w;
  assign lk_o.lru_st   = lru_st_w;
  assign lk_o.lru_rank = lru_rank_w;
  assign lk_o.lru_tag  = oh_tag(lru_w, tags_i);
  assign lk_o.mod_mask = mod_w;

endmodule

[hdl/cache_set_lru_mesi.sv]
// ----------------------------------------------------------------------------
// cache_set_lru_mesi
// One set of an eight-way cache with true LRU ranks and MESI line states.
// ----------------------------------------------------------------------------
// Requests arrive on req_i (type and tag) and results leave on rsp_o, both
// valid/ready channels. Every request gives one result beat, except a clear
// of the set, which gives one beat per modified line (at least one beat).
// The beat with last set closes the request.
// The result of an accepted request sits in the output register from the
// cycle after acceptance. The block takes one request per cycle while the
// output register can take a beat and no clear is draining; the tag compare
// and re-ranking of all ways finish between the state registers and the
// output register. A clear that writes back n modified lines holds ready low
// while its remaining n-1 beats drain from the pending mask.
// When the receiver stalls, the output register holds its beat and ready
// drops until it is taken; a beat taken in a cycle frees the register for a
// new request in that same cycle.
// Reset marks every way invalid and clears the ranks, line count and output
// register. Tags are not reset; only tags of valid or pending lines are read.
// ----------------------------------------------------------------------------
module cache_set_lru_mesi (
  input  logic      clk_i,
  input  logic      rst_ni,
  csl_req_if.sink   req_i,
  csl_rsp_if.source rsp_o
);
  import csl_pkg::*;

  tag_arr_t            tag_q, tag_d;
  st_arr_t             st_q, st_d;
  rank_arr_t           rank_q, rank_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  way_vec_t            pend_q, pend_d;
  logic                ov_q, ov_d;
  rsp_t                rsp_q, rsp_d;

  lookup_t  lk;
  tag_t     req_tag_w;
  logic     out_free;
  logic     accept;
  logic     full;
  way_vec_t pend_first;
  way_vec_t mod_first;
  way_vec_t fill_oh;
  mesi_e    fill_st;

  assign req_tag_w  = req_i.req_tag[TAG_BITS-1:0];
  assign out_free   = !ov_q || rsp_o.ready;
  assign req_i.ready = (pend_q == '0) && out_free;
  assign accept     = req_i.valid && req_i.ready;
  assign full       = (cnt_q == CNT_BITS'(WAYS));
  assign pend_first = pend_q & (~pend_q + way_vec_t'(1));
  assign mod_first  = lk.mod_mask & (~lk.mod_mask + way_vec_t'(1));
  assign fill_oh    = full ? lk.lru_oh : lk.free_oh;
  assign fill_st    = (req_i.req_type == RT_WRITE) ? ST_E : ST_S;

  csl_lookup u_lookup (
    .tag_i  (req_tag_w),
    .tags_i (tag_q),
    .st_i   (st_q),
    .rank_i (rank_q),
    .lk_o   (lk)
  );

  always_comb begin
    tag_d  = tag_q;
    st_d   = st_q;
    rank_d = rank_q;
    cnt_d  = cnt_q;
    pend_d = pend_q;
    ov_d   = ov_q;
    rsp_d  = rsp_q;

    if (ov_q && rsp_o.ready) begin
      ov_d = 1'b0;
    end

    if ((pend_q != '0) && out_free) begin
      // Remaining write-back beats of a clear, lowest way first.
      rsp_d            = '0;
      rsp_d.writeback  = 1'b1;
      rsp_d.victim_tag = oh_tag(pend_first, tag_q);
      rsp_d.last       = ((pend_q & ~pend_first) == '0);
      pend_d           = pend_q & ~pend_first;
      ov_d             = 1'b1;
    end else if (accept) begin
      rsp_d      = '0;
      rsp_d.last = 1'b1;
      ov_d       = 1'b1;
      case (req_i.req_type)
        RT_READ, RT_WRITE, RT_SNOOP: begin
          if (lk.hit) begin
            rsp_d.hit = 1'b1;
            for (int k = 0; k < WAYS; k++) begin
              if ((st_q[k] != ST_I) && (rank_q[k] < lk.hit_rank)) begin
                rank_d[k] = rank_q[k] + rank_t'(1);
              end
              if (lk.hit_oh[k]) begin
                rank_d[k] = '0;
              end
            end
            if (req_i.req_type == RT_SNOOP) begin
              rsp_d.snoop_return = (lk.hit_st == ST_M) || (lk.hit_st == ST_E);
              for (int k = 0; k < WAYS; k++) begin
                if (lk.hit_oh[k]) st_d[k] = ST_S;
              end
            end else if (req_i.req_type == RT_WRITE) begin
              for (int k = 0; k < WAYS; k++) begin
                if (lk.hit_oh[k] && (st_q[k] == ST_E)) st_d[k] = ST_M;
                if (lk.hit_oh[k] && (st_q[k] == ST_S)) st_d[k] = ST_E;
              end
            end
          end else if (req_i.req_type != RT_SNOOP) begin
            // Miss fill: a full set reuses its LRU way, which acts as a promote.
            rsp_d.fetch_from_l2 = 1'b1;
            rsp_d.write_through = (req_i.req_type == RT_WRITE);
            rsp_d.writeback     = full && (lk.lru_st == ST_M);
            rsp_d.victim_tag    = (full && (lk.lru_st == ST_M)) ? lk.lru_tag : '0;
            for (int k = 0; k < WAYS; k++) begin
              if ((st_q[k] != ST_I) && (!full || (rank_q[k] < lk.lru_rank))) begin
                rank_d[k] = rank_q[k] + rank_t'(1);
              end
              if (fill_oh[k]) begin
                tag_d[k]  = req_tag_w;
                st_d[k]   = fill_st;
                rank_d[k] = '0;
              end
            end
            if (!full) begin
              cnt_d = cnt_q + CNT_BITS'(1);
            end
          end
        end
        RT_INV: begin
          if (lk.hit) begin
            rsp_d.hit        = 1'b1;
            rsp_d.writeback  = (lk.hit_st == ST_M);
            rsp_d.victim_tag = (lk.hit_st == ST_M) ? req_tag_w : '0;
            for (int k = 0; k < WAYS; k++) begin
              if ((st_q[k] != ST_I) && !lk.hit_oh[k] && (rank_q[k] > lk.hit_rank)) begin
                rank_d[k] = rank_q[k] - rank_t'(1);
              end
              if (lk.hit_oh[k]) begin
                st_d[k]   = ST_I;
                rank_d[k] = '0;
              end
            end
            if (cnt_q != '0) begin
              cnt_d = cnt_q - CNT_BITS'(1);
            end
          end
        end
        RT_CLEAR: begin
          for (int k = 0; k < WAYS; k++) begin
            st_d[k]   = ST_I;
            rank_d[k] = '0;
          end
          cnt_d = '0;
          if (lk.mod_mask != '0) begin
            rsp_d.writeback  = 1'b1;
            rsp_d.victim_tag = oh_tag(mod_first, tag_q);
            rsp_d.last       = ((lk.mod_mask & ~mod_first) == '0);
            pend_d           = lk.mod_mask & ~mod_first;
          end
        end
        default: begin
          // Unknown request types leave the set alone.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= {WAYS{ST_I}};
      rank_q <= '0;
      cnt_q  <= '0;
      pend_q <= '0;
      ov_q   <= 1'b0;
      rsp_q  <= '0;
    end else begin
      st_q   <= st_d;
      rank_q <= rank_d;
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
      ov_q   <= ov_d;
      rsp_q  <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
  end

  assign rsp_o.valid         = ov_q;
  assign rsp_o.hit           = rsp_q.hit;
  assign rsp_o.fetch_from_l2 = rsp_q.fetch_from_l2;
  assign rsp_o.write_through = rsp_q.write_through;
  assign rsp_o.writeback     = rsp_q.writeback;
  assign rsp_o.victim_tag    = rsp_q.victim_tag;
  assign rsp_o.snoop_return  = rsp_q.snoop_return;
  assign rsp_o.last          = rsp_q.last;

endmodule

[hdl/csl_checker.sv]
// ----------------------------------------------------------------------------
// csl_checker
// Port-level checks of the cache set, bound to the top level.
// ----------------------------------------------------------------------------
`include "cache_set_lru_mesi_macros.svh"

module csl_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic                         rsp_hit_i,
  input logic                         rsp_fetch_i,
  input logic                         rsp_wt_i,
  input logic                         rsp_wb_i,
  input logic [csl_pkg::TAG_BITS-1:0] rsp_victim_i,
  input logic                         rsp_snoop_i,
  input logic                         rsp_last_i
);
  import csl_pkg::*;

  // A stalled beat keeps its victim tag, last and writeback flags.
  `CSL_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i,
    rsp_valid_i && $stable(rsp_victim_i) && $stable(rsp_last_i) && $stable(rsp_wb_i))

  // Only a clear emits non-final beats, each a write-back, and no new request
  // enters while it drains.
  `CSL_ASSERT_IMP(a_drain_beat, clk_i, rst_ni, rsp_valid_i && !rsp_last_i,
    rsp_wb_i && !rsp_hit_i && !req_ready_i)

  `CSL_ASSERT_IMP(a_victim_zero, clk_i, rst_ni, rsp_valid_i && !rsp_wb_i,
    rsp_victim_i == '0)

  // A write miss fetches, and a snoop return needs a hit.
  `CSL_ASSERT_IMP(a_miss_flags, clk_i, rst_ni, rsp_valid_i && (rsp_wt_i || rsp_snoop_i),
    (rsp_wt_i && rsp_fetch_i && !rsp_hit_i && !rsp_snoop_i)
    || (rsp_snoop_i && rsp_hit_i && !rsp_fetch_i))

endmodule

bind cache_set_lru_mesi csl_checker u_csl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_hit_i    (rsp_o.hit),
  .rsp_fetch_i  (rsp_o.fetch_from_l2),
  .rsp_wt_i     (rsp_o.write_through),
  .rsp_wb_i     (rsp_o.writeback),
  .rsp_victim_i (rsp_o.victim_tag),
  .rsp_snoop_i  (rsp_o.snoop_return),
  .rsp_last_i   (rsp_o.last)
);

[tb/sv/cache_set_lru_mesi_tb.sv]
// ----------------------------------------------------------------------------
// cache_set_lru_mesi_tb
// Self-checking bench for one LRU/MESI cache set.
// ----------------------------------------------------------------------------
// A short table of requests walks through the MESI transitions, eviction with
// a writeback, and clears of the set. A random run on a small hot
// set of tags then follows. A behavioral copy of the set predicts every
// result beat, and each beat leaving the block is checked field by field.
// Both channels idle in random bursts. A long receiver stall and a sender
// pause until the set has drained are also included.
// ----------------------------------------------------------------------------
module cache_set_lru_mesi_tb;
  import csl_pkg::*;

  localparam int N_DIRECTED  = 26;
  localparam int N_RANDOM    = 400;
  localparam int N_CALM      = 60;
  localparam int HOLD_CYCLES = 160;
  localparam int POOL_SIZE   = 12;

  typedef struct packed {
    req_type_e kind;
    tag_t      tag;
    logic      typed;
    rsp_t      beat;
  } dir_row_t;

  // Fields in order: hit, fetch, write-through, writeback, victim, snoop, last.
  localparam rsp_t B_NONE    = '{1'b0, 1'b0, 1'b0, 1'b0, 12'h000, 1'b0, 1'b1};
  localparam rsp_t B_HIT     = '{1'b1, 1'b0, 1'b0, 1'b0, 12'h000, 1'b0, 1'b1};
  localparam rsp_t B_RD_FILL = '{1'b0, 1'b1, 1'b0, 1'b0, 12'h000, 1'b0, 1'b1};
  localparam rsp_t B_WR_FILL = '{1'b0, 1'b1, 1'b1, 1'b0, 12'h000, 1'b0, 1'b1};
  localparam rsp_t B_SNP_RET = '{1'b1, 1'b0, 1'b0, 1'b0, 12'h000, 1'b1, 1'b1};

  localparam dir_row_t DIR_ROWS [N_DIRECTED] = '{
    '{RT_READ,  12'h000, 1'b1, B_RD_FILL},
    '{RT_WRITE, 12'hFFF, 1'b1, B_WR_FILL},
    '{RT_WRITE, 12'hFFF, 1'b1, B_HIT},      // exclusive to modified
    '{RT_WRITE, 12'hFFF, 1'b1, B_HIT},      // modified stays modified
    '{RT_SNOOP, 12'hFFF, 1'b1, B_SNP_RET},  // modified to shared
    '{RT_SNOOP, 12'hFFF, 1'b1, B_HIT},      // shared line, no data back
    '{RT_WRITE, 12'hFFF, 1'b1, B_HIT},      // shared to exclusive
    '{RT_SNOOP, 12'hFFF, 1'b1, B_SNP_RET},  // exclusive to shared
    '{RT_INV,   12'hFFF, 1'b1, B_HIT},
    '{RT_INV,   12'hFFF, 1'b1, B_NONE},
    '{RT_SNOOP, 12'h123, 1'b1, B_NONE},
    '{RT_READ,  12'h000, 1'b1, B_HIT},
    '{RT_CLEAR, 12'h000, 1'b1, B_NONE},     // nothing modified
    '{RT_WRITE, 12'h001, 1'b1, B_WR_FILL},
    '{RT_WRITE, 12'h001, 1'b1, B_HIT},
    '{RT_WRITE, 12'h002, 1'b0, B_NONE},
    '{RT_WRITE, 12'h004, 1'b0, B_NONE},
    '{RT_WRITE, 12'h008, 1'b0, B_NONE},
    '{RT_WRITE, 12'h010, 1'b0, B_NONE},
    '{RT_WRITE, 12'h020, 1'b0, B_NONE},
    '{RT_WRITE, 12'h040, 1'b0, B_NONE},
    '{RT_WRITE, 12'h080, 1'b0, B_NONE},
    '{RT_READ,  12'h800, 1'b0, B_NONE},     // full set, modified victim
    '{RT_WRITE, 12'h004, 1'b0, B_NONE},
    '{RT_WRITE, 12'h040, 1'b0, B_NONE},
    '{RT_CLEAR, 12'h000, 1'b0, B_NONE}      // two writeback beats
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  csl_req_if req_bus ();
  csl_rsp_if rsp_bus ();

  cache_set_lru_mesi i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the set.
  tag_t        line_tag  [WAYS];
  mesi_e       line_st   [WAYS];
  rank_t       line_rank [WAYS];
  int unsigned n_lines;

  rsp_t due_beats [$];
  int   err_cnt = 0;
  bit   calm = 1'b0;
  bit   hold_rsp = 1'b0;
  tag_t tag_pool [POOL_SIZE];

  function automatic rsp_t beat_of(logic h, logic f, logic wt, logic wb, tag_t vt,
                                   logic sr, logic l);
    rsp_t b;
    b = '{h, f, wt, wb, vt, sr, l};
    return b;
  endfunction

  function automatic int find_line(tag_t t);
    for (int w = 0; w < WAYS; w++) begin
      if (line_st[w] != ST_I && line_tag[w] == t) return w;
    end
    return -1;
  endfunction

  function automatic void promote_line(int w);
    rank_t r;
    r = line_rank[w];
    for (int k = 0; k < WAYS; k++) begin
      if (line_st[k] != ST_I && line_rank[k] < r) line_rank[k] = line_rank[k] + 1'b1;
    end
    line_rank[w] = '0;
  endfunction

  function automatic void drop_line(int w);
    rank_t r;
    r = line_rank[w];
    for (int k = 0; k < WAYS; k++) begin
      if (k != w && line_st[k] != ST_I && line_rank[k] > r) begin
        line_rank[k] = line_rank[k] - 1'b1;
      end
    end
    line_st[w]   = ST_I;
    line_rank[w] = '0;
    if (n_lines > 0) n_lines--;
  endfunction

  // Evicts the least recent line when the set is full, then installs the tag.
  function automatic void fill_line(tag_t t, mesi_e st, output logic wb, output tag_t victim);
    int slot;
    int lru;
    slot   = -1;
    wb     = 1'b0;
    victim = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (slot < 0 && line_st[w] == ST_I) slot = w;
    end
    if (slot < 0) begin
      lru = 0;
      for (int w = 1; w < WAYS; w++) begin
        if (line_rank[w] > line_rank[lru]) lru = w;
      end
      if (line_st[lru] == ST_M) begin
        wb     = 1'b1;
        victim = line_tag[lru];
      end
      drop_line(lru);
      slot = lru;
    end
    for (int w = 0; w < WAYS; w++) begin
      if (line_st[w] != ST_I) line_rank[w] = line_rank[w] + 1'b1;
    end
    line_tag[slot]  = t;
    line_st[slot]   = st;
    line_rank[slot] = '0;
    n_lines++;
  endfunction

  // Updates the shadow set for one request and queues the beats it causes.
  function automatic void apply_request(req_type_e kind, tag_t t);
    int   w;
    int   n_wb;
    logic wb;
    logic mod;
    tag_t victim;
    w = find_line(t);
    case (kind)
      RT_READ: begin
        if (w >= 0) begin
          promote_line(w);
          due_beats.push_back(B_HIT);
        end else begin
          fill_line(t, ST_S, wb, victim);
          due_beats.push_back(beat_of(1'b0, 1'b1, 1'b0, wb, victim, 1'b0, 1'b1));
        end
      end
      RT_WRITE: begin
        if (w >= 0) begin
          if (line_st[w] == ST_E) line_st[w] = ST_M;
          else if (line_st[w] == ST_S) line_st[w] = ST_E;
          promote_line(w);
          due_beats.push_back(B_HIT);
        end else begin
          fill_line(t, ST_E, wb, victim);
          due_beats.push_back(beat_of(1'b0, 1'b1, 1'b1, wb, victim, 1'b0, 1'b1));
        end
      end
      RT_SNOOP: begin
        if (w >= 0) begin
          mod = (line_st[w] == ST_M || line_st[w] == ST_E);
          line_st[w] = ST_S;
          promote_line(w);
          due_beats.push_back(beat_of(1'b1, 1'b0, 1'b0, 1'b0, '0, mod, 1'b1));
        end else begin
          due_beats.push_back(B_NONE);
        end
      end
      RT_INV: begin
        if (w >= 0) begin
          mod = (line_st[w] == ST_M);
          drop_line(w);
          due_beats.push_back(beat_of(1'b1, 1'b0, 1'b0, mod, mod ? t : '0, 1'b0, 1'b1));
        end else begin
          due_beats.push_back(B_NONE);
        end
      end
      RT_CLEAR: begin
        n_wb = 0;
        for (int k = 0; k < WAYS; k++) begin
          if (line_st[k] == ST_M) begin
            due_beats.push_back(beat_of(1'b0, 1'b0, 1'b0, 1'b1, line_tag[k], 1'b0, 1'b0));
            n_wb++;
          end
          line_st[k]   = ST_I;
          line_rank[k] = '0;
        end
        n_lines = 0;
        if (n_wb == 0) due_beats.push_back(B_NONE);
        else due_beats[due_beats.size()-1].last = 1'b1;
      end
      default: begin
        due_beats.push_back(B_NONE);
      end
    endcase
  endfunction

  function automatic void check_field(string name, tag_t want, tag_t got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  task automatic pause_req(int n);
    req_bus.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic gap_maybe();
    if (!calm && $urandom_range(0, 4) == 0) pause_req($urandom_range(1, 11));
  endtask

  task automatic send_req(req_type_e kind, tag_t t, logic typed, rsp_t fixed);
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.req_tag  <= t;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    apply_request(kind, t);
    // A typed row is a single-beat request; its beat replaces the computed one.
    if (typed) begin
      void'(due_beats.pop_back());
      due_beats.push_back(fixed);
    end
  endtask

  // Receiver side: random stalls, one long hold-off on request, none at the end.
  initial begin : rsp_drive
    rsp_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_rsp) begin
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rsp = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rsp_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        rsp_bus.ready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : rsp_check
    rsp_t exp_beat;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (due_beats.size() == 0) begin
        $error("result beat with nothing outstanding");
        err_cnt++;
      end else begin
        exp_beat = due_beats.pop_front();
        check_field("hit",           tag_t'(exp_beat.hit),           tag_t'(rsp_bus.hit));
        check_field("fetch_from_l2", tag_t'(exp_beat.fetch_from_l2), tag_t'(rsp_bus.fetch_from_l2));
        check_field("write_through", tag_t'(exp_beat.write_through), tag_t'(rsp_bus.write_through));
        check_field("writeback",     tag_t'(exp_beat.writeback),     tag_t'(rsp_bus.writeback));
        check_field("victim_tag",    exp_beat.victim_tag,            rsp_bus.victim_tag);
        check_field("snoop_return",  tag_t'(exp_beat.snoop_return),  tag_t'(rsp_bus.snoop_return));
        check_field("last",          tag_t'(exp_beat.last),          tag_t'(rsp_bus.last));
      end
    end
  end

  initial begin : req_drive
    req_type_e kind;
    tag_t      t;
    int        pick;
    rst_ni           = 1'b0;
    req_bus.valid    = 1'b0;
    req_bus.req_type = RT_READ;
    req_bus.req_tag  = '0;
    for (int w = 0; w < WAYS; w++) begin
      line_tag[w]  = '0;
      line_st[w]   = ST_I;
      line_rank[w] = '0;
    end
    n_lines = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      gap_maybe();
      send_req(DIR_ROWS[i].kind, DIR_ROWS[i].tag, DIR_ROWS[i].typed, DIR_ROWS[i].beat);
    end

    // A pool a little larger than the set keeps hits, evictions and writebacks frequent.
    for (int k = 0; k < POOL_SIZE; k++) tag_pool[k] = tag_t'($urandom_range(0, 4095));

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - N_CALM) calm = 1'b1;
      if (i == 120) hold_rsp = 1'b1;
      if (i == 260) begin
        pause_req(1);
        while (due_beats.size() != 0) @(posedge clk_i);
      end
      gap_maybe();
      pick = $urandom_range(0, 99);
      if (pick < 36) kind = RT_READ;
      else if (pick < 70) kind = RT_WRITE;
      else if (pick < 82) kind = RT_SNOOP;
      else if (pick < 95) kind = RT_INV;
      else kind = RT_CLEAR;
      if ($urandom_range(0, 9) == 0) t = tag_t'($urandom_range(0, 4095));
      else t = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
      if ($urandom_range(0, 29) == 0) begin
        tag_pool[$urandom_range(0, POOL_SIZE - 1)] = tag_t'($urandom_range(0, 4095));
      end
      send_req(kind, t, 1'b0, B_NONE);
    end

    req_bus.valid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("cache_set_lru_mesi verification clean");
    end else begin
      $display("cache_set_lru_mesi verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("cache_set_lru_mesi verification failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/csl_pkg.sv
hdl/csl_if.sv
hdl/csl_lookup.sv
hdl/cache_set_lru_mesi.sv
hdl/csl_checker.sv
tb/sv/cache_set_lru_mesi_tb.sv
